@@ rtl/cbc_pkg.sv @@
// shared types and constants for the color band classifier
package cbc_pkg;

    localparam int NUM_COLORS     = 9;
    localparam int COUNT_BITS_DEF = 20;
    localparam int FRAC_BITS      = 16;
    localparam int IDX_BITS       = 4;
    localparam int OUT_DATA_BITS  = 24;

    // rounding constant for q0.16 products, one half lsb
    localparam logic [FRAC_BITS-1:0] ROUND_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    // register reset values, q0.16
    localparam logic [FRAC_BITS-1:0] MIN_FRACTION_RST  = 16'd3277;
    localparam logic [FRAC_BITS-1:0] PRIME_FRACTION_RST = 16'd13107;
    localparam logic [FRAC_BITS-1:0] DOM_RECIP_RST      = 16'd32768;
    localparam logic [FRAC_BITS-1:0] SEC_FRACTION_RST   = 16'd19661;

    typedef enum logic [1:0] {
        REG_MIN_FRACTION  = 2'd0,
        REG_PRIME_FRACTION = 2'd1,
        REG_DOM_RECIP      = 2'd2,
        REG_SEC_FRACTION   = 2'd3
    } cbc_reg_t;

    // largest-count winner: found only when some count beat the minimum
    typedef struct packed {
        logic                found;
        logic [IDX_BITS-1:0] idx;
    } cbc_peak_t;

endpackage

@@ rtl/cbc_totals.sv @@
// stages one and two: count sum, then minimum and prime thresholds
module cbc_totals #(
    parameter int COUNT_BITS = cbc_pkg::COUNT_BITS_DEF
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  in_valid,
    output logic                                                  in_ready,
    input  logic [cbc_pkg::NUM_COLORS-1:0][COUNT_BITS-1:0]        in_counts,
    input  logic [cbc_pkg::FRAC_BITS-1:0]                         min_frac,
    input  logic [cbc_pkg::FRAC_BITS-1:0]                         prime_frac,
    output logic                                                  out_valid,
    input  logic                                                  out_ready,
    output logic [cbc_pkg::NUM_COLORS-1:0][COUNT_BITS-1:0]        out_counts,
    output logic [COUNT_BITS+3:0]                                 out_lo,
    output logic [COUNT_BITS+3:0]                                 out_prime
);
    localparam int SUM_BITS  = COUNT_BITS + 4;
    localparam int PROD_BITS = SUM_BITS + cbc_pkg::FRAC_BITS + 1;

    logic                                           s1_valid_reg;
    logic [cbc_pkg::NUM_COLORS-1:0][COUNT_BITS-1:0] s1_counts_reg;
    logic [SUM_BITS-1:0]                            s1_sum_reg;
    logic [SUM_BITS-1:0]                            s1_sum_next;
    logic                                           s1_ready;

    logic                                           s2_valid_reg;
    logic [cbc_pkg::NUM_COLORS-1:0][COUNT_BITS-1:0] s2_counts_reg;
    logic [SUM_BITS-1:0]                            s2_lo_reg;
    logic [SUM_BITS-1:0]                            s2_prime_reg;
    logic [PROD_BITS-1:0]                           lo_prod;
    logic [PROD_BITS-1:0]                           prime_prod;
    logic                                           s2_ready;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb begin
        s1_sum_next = '0;
        for (int i = 0; i < cbc_pkg::NUM_COLORS; i++) begin
            s1_sum_next = s1_sum_next + SUM_BITS'(in_counts[i]);
        end
    end

    // rounded half up q0.16 products
    assign lo_prod    = PROD_BITS'(s1_sum_reg) * PROD_BITS'(min_frac)
                      + PROD_BITS'(cbc_pkg::ROUND_HALF);
    assign prime_prod = PROD_BITS'(s1_sum_reg) * PROD_BITS'(prime_frac)
                      + PROD_BITS'(cbc_pkg::ROUND_HALF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_counts_reg <= in_counts;
            s1_sum_reg    <= s1_sum_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_counts_reg <= s1_counts_reg;
            s2_lo_reg     <= lo_prod[SUM_BITS+cbc_pkg::FRAC_BITS-1:cbc_pkg::FRAC_BITS];
            s2_prime_reg  <= prime_prod[SUM_BITS+cbc_pkg::FRAC_BITS-1:cbc_pkg::FRAC_BITS];
        end
    end

    assign out_valid  = s2_valid_reg;
    assign out_counts = s2_counts_reg;
    assign out_lo     = s2_lo_reg;
    assign out_prime  = s2_prime_reg;

endmodule

@@ rtl/cbc_peak.sv @@
// stages three and four: largest count above minimum, then dominance and secondary levels
module cbc_peak #(
    parameter int COUNT_BITS = cbc_pkg::COUNT_BITS_DEF
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  logic [cbc_pkg::NUM_COLORS-1:0][COUNT_BITS-1:0] in_counts,
    input  logic [COUNT_BITS+3:0]                          in_lo,
    input  logic [COUNT_BITS+3:0]                          in_prime,
    input  logic [cbc_pkg::FRAC_BITS-1:0]                  dom_recip,
    input  logic [cbc_pkg::FRAC_BITS-1:0]                  sec_frac,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output logic [cbc_pkg::NUM_COLORS-1:0][COUNT_BITS-1:0] out_counts,
    output logic [COUNT_BITS+3:0]                          out_lo,
    output logic [COUNT_BITS+3:0]                          out_prime,
    output logic [COUNT_BITS+3:0]                          out_hi,
    output cbc_pkg::cbc_peak_t                             out_peak,
    output logic [COUNT_BITS+3:0]                          out_dom_th,
    output logic [COUNT_BITS+3:0]                          out_sec_th
);
    localparam int SUM_BITS  = COUNT_BITS + 4;
    localparam int PROD_BITS = SUM_BITS + cbc_pkg::FRAC_BITS + 1;

    typedef struct packed {
        logic                         found;
        logic [cbc_pkg::IDX_BITS-1:0] idx;
        logic [COUNT_BITS-1:0]        val;
    } node_t;

    // lower index sits in a; b wins only when strictly larger
    function automatic node_t pick(input node_t a, input node_t b);
        node_t r;
        if (b.found && (!a.found || (b.val > a.val))) begin
            r = b;
        end else begin
            r = a;
        end
        return r;
    endfunction

    node_t leaf [cbc_pkg::NUM_COLORS];
    node_t lvl1 [4];
    node_t lvl2 [2];
    node_t lvl3;
    node_t best;

    logic                                           s3_valid_reg;
    logic [cbc_pkg::NUM_COLORS-1:0][COUNT_BITS-1:0] s3_counts_reg;
    logic [SUM_BITS-1:0]                            s3_lo_reg;
    logic [SUM_BITS-1:0]                            s3_prime_reg;
    logic [SUM_BITS-1:0]                            s3_hi_reg;
    cbc_pkg::cbc_peak_t                             s3_peak_reg;
    logic                                           s3_ready;

    logic                                           s4_valid_reg;
    logic [cbc_pkg::NUM_COLORS-1:0][COUNT_BITS-1:0] s4_counts_reg;
    logic [SUM_BITS-1:0]                            s4_lo_reg;
    logic [SUM_BITS-1:0]                            s4_prime_reg;
    logic [SUM_BITS-1:0]                            s4_hi_reg;
    cbc_pkg::cbc_peak_t                             s4_peak_reg;
    logic [SUM_BITS-1:0]                            s4_dom_reg;
    logic [SUM_BITS-1:0]                            s4_sec_reg;
    logic                                           s4_ready;

    logic [PROD_BITS-1:0]                           dom_prod;
    logic [PROD_BITS-1:0]                           sec_prod;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign in_ready = s3_ready;

    // balanced max tree over counts strictly above the minimum
    always_comb begin
        for (int i = 0; i < cbc_pkg::NUM_COLORS; i++) begin
            leaf[i].found = SUM_BITS'(in_counts[i]) > in_lo;
            leaf[i].idx   = cbc_pkg::IDX_BITS'(i);
            leaf[i].val   = in_counts[i];
        end
        for (int i = 0; i < 4; i++) begin
            lvl1[i] = pick(leaf[2*i], leaf[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
        end
        lvl3 = pick(lvl2[0], lvl2[1]);
        best = pick(lvl3, leaf[8]);
    end

    assign dom_prod = PROD_BITS'(s3_hi_reg) * PROD_BITS'(dom_recip)
                    + PROD_BITS'(cbc_pkg::ROUND_HALF);
    assign sec_prod = PROD_BITS'(s3_hi_reg) * PROD_BITS'(sec_frac)
                    + PROD_BITS'(cbc_pkg::ROUND_HALF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (s3_ready) begin
                s3_valid_reg <= in_valid;
            end
            if (s4_ready) begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && in_valid) begin
            s3_counts_reg     <= in_counts;
            s3_lo_reg         <= in_lo;
            s3_prime_reg      <= in_prime;
            s3_hi_reg         <= best.found ? SUM_BITS'(best.val) : in_lo;
            s3_peak_reg.found <= best.found;
            s3_peak_reg.idx   <= best.idx;
        end
        if (s4_ready && s3_valid_reg) begin
            s4_counts_reg <= s3_counts_reg;
            s4_lo_reg     <= s3_lo_reg;
            s4_prime_reg  <= s3_prime_reg;
            s4_hi_reg     <= s3_hi_reg;
            s4_peak_reg   <= s3_peak_reg;
            s4_dom_reg    <= dom_prod[SUM_BITS+cbc_pkg::FRAC_BITS-1:cbc_pkg::FRAC_BITS];
            s4_sec_reg    <= sec_prod[SUM_BITS+cbc_pkg::FRAC_BITS-1:cbc_pkg::FRAC_BITS];
        end
    end

    assign out_valid  = s4_valid_reg;
    assign out_counts = s4_counts_reg;
    assign out_lo     = s4_lo_reg;
    assign out_prime  = s4_prime_reg;
    assign out_hi     = s4_hi_reg;
    assign out_peak   = s4_peak_reg;
    assign out_dom_th = s4_dom_reg;
    assign out_sec_th = s4_sec_reg;

endmodule

@@ rtl/cbc_mark.sv @@
// stage five: primary and secondary marking into the output register
module cbc_mark #(
    parameter int COUNT_BITS = cbc_pkg::COUNT_BITS_DEF
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  logic [cbc_pkg::NUM_COLORS-1:0][COUNT_BITS-1:0] in_counts,
    input  logic [COUNT_BITS+3:0]                          in_lo,
    input  logic [COUNT_BITS+3:0]                          in_prime,
    input  logic [COUNT_BITS+3:0]                          in_hi,
    input  cbc_pkg::cbc_peak_t                             in_peak,
    input  logic [COUNT_BITS+3:0]                          in_dom_th,
    input  logic [COUNT_BITS+3:0]                          in_sec_th,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output logic [cbc_pkg::NUM_COLORS-1:0]                 out_primary,
    output logic [cbc_pkg::NUM_COLORS-1:0]                 out_secondary,
    output logic                                           out_single
);
    localparam int SUM_BITS = COUNT_BITS + 4;

    logic [cbc_pkg::NUM_COLORS-1:0] above_dom;
    logic [cbc_pkg::NUM_COLORS-1:0] above_sec;
    logic [cbc_pkg::NUM_COLORS-1:0] prim_next;
    logic                           beaten;
    logic                           single_next;
    logic [SUM_BITS-1:0]            sec_level;

    logic                           o_valid_reg;
    logic [cbc_pkg::NUM_COLORS-1:0] o_prim_reg;
    logic [cbc_pkg::NUM_COLORS-1:0] o_sec_reg;
    logic                           o_single_reg;

    assign in_ready  = !o_valid_reg || out_ready;
    assign sec_level = (in_sec_th < in_lo) ? in_lo : in_sec_th;

    always_comb begin
        beaten = 1'b0;
        for (int i = 0; i < cbc_pkg::NUM_COLORS; i++) begin
            above_dom[i] = SUM_BITS'(in_counts[i]) > in_dom_th;
            above_sec[i] = SUM_BITS'(in_counts[i]) >= sec_level;
            if ((cbc_pkg::IDX_BITS'(i) != in_peak.idx) && above_dom[i]) begin
                beaten = 1'b1;
            end
        end
        single_next = in_peak.found && !beaten;
        if (single_next) begin
            prim_next = cbc_pkg::NUM_COLORS'(1) << in_peak.idx;
        end else if (in_hi >= in_prime) begin
            prim_next = above_dom;
        end else begin
            prim_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (in_ready) begin
            o_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            o_prim_reg   <= prim_next;
            o_sec_reg    <= above_sec & ~prim_next;
            o_single_reg <= single_next;
        end
    end

    assign out_valid     = o_valid_reg;
    assign out_primary   = o_prim_reg;
    assign out_secondary = o_sec_reg;
    assign out_single    = o_single_reg;

endmodule

@@ rtl/color_band_classifier.sv @@
// top level of the color band classifier: config registers and five-stage pipeline
//
// Classifies one object's color content from nine pixel counts (red, orange,
// yellow, green, blue, purple, black, gray, white; bit 0 to bit 8 of each mask).
// The counts are summed; a minimum and a prime threshold are taken from the total
// with q0.16 fractions rounded half up. The largest count strictly above the
// minimum wins (lowest color on ties). If no other count exceeds
// largest * dominance_reciprocal the winner alone is primary and single_dominant
// is set; otherwise, when the largest reaches the prime threshold, every count
// above the dominance level is primary. Counts at or above max(minimum, largest *
// secondary_fraction) that are not primary are secondary. With no count above
// the minimum, the minimum itself stands in for the largest.
// Throughput is one beat per clock while no stall holds the pipe: a new object is
// taken every cycle, and the result passes through one register stage each for
// the sum, the total-based products, the max tree, the largest-based products
// and the marking compare, the last being the output register. A stalled m_tready
// holds only the stages that are full; empty stages keep taking input.
// Config registers: index 0 min_fraction, 1 prime_fraction,
// 2 dominance_reciprocal, 3 secondary_fraction; write them only while no beat is
// in flight.
module color_band_classifier #(
    parameter int COUNT_BITS = cbc_pkg::COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write port
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_addr,
    input  logic [15:0]          cfg_wdata,
    // input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // red, orange, yellow, green, blue, purple, black, gray, white counts, zero pad
    input  logic [((cbc_pkg::NUM_COLORS*COUNT_BITS+7)/8)*8-1:0] s_tdata,
    // result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // primary_mask [8:0], secondary_mask [17:9], single_dominant [18], zero pad
    output logic [cbc_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    localparam int SUM_BITS = COUNT_BITS + 4;
    localparam int PAD_BITS = cbc_pkg::OUT_DATA_BITS - 2 * cbc_pkg::NUM_COLORS - 1;

    // q0.16 fraction registers
    logic [cbc_pkg::FRAC_BITS-1:0] min_frac_reg;
    logic [cbc_pkg::FRAC_BITS-1:0] prime_frac_reg;
    logic [cbc_pkg::FRAC_BITS-1:0] dom_recip_reg;
    logic [cbc_pkg::FRAC_BITS-1:0] sec_frac_reg;

    logic [cbc_pkg::NUM_COLORS-1:0][COUNT_BITS-1:0] in_counts;

    // totals -> peak
    logic                                           tp_valid;
    logic                                           tp_ready;
    logic [cbc_pkg::NUM_COLORS-1:0][COUNT_BITS-1:0] tp_counts;
    logic [SUM_BITS-1:0]                            tp_lo;
    logic [SUM_BITS-1:0]                            tp_prime;

    // peak -> mark
    logic                                           pm_valid;
    logic                                           pm_ready;
    logic [cbc_pkg::NUM_COLORS-1:0][COUNT_BITS-1:0] pm_counts;
    logic [SUM_BITS-1:0]                            pm_lo;
    logic [SUM_BITS-1:0]                            pm_prime;
    logic [SUM_BITS-1:0]                            pm_hi;
    cbc_pkg::cbc_peak_t                             pm_peak;
    logic [SUM_BITS-1:0]                            pm_dom_th;
    logic [SUM_BITS-1:0]                            pm_sec_th;

    logic [cbc_pkg::NUM_COLORS-1:0]                 primary_mask;
    logic [cbc_pkg::NUM_COLORS-1:0]                 secondary_mask;
    logic                                           single_dominant;

    // config writes; every 2-bit index maps onto a register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_frac_reg   <= cbc_pkg::MIN_FRACTION_RST;
            prime_frac_reg <= cbc_pkg::PRIME_FRACTION_RST;
            dom_recip_reg  <= cbc_pkg::DOM_RECIP_RST;
            sec_frac_reg   <= cbc_pkg::SEC_FRACTION_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                cbc_pkg::REG_MIN_FRACTION:   min_frac_reg   <= cfg_wdata;
                cbc_pkg::REG_PRIME_FRACTION: prime_frac_reg <= cfg_wdata;
                cbc_pkg::REG_DOM_RECIP:      dom_recip_reg  <= cfg_wdata;
                cbc_pkg::REG_SEC_FRACTION:   sec_frac_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // unpack the nine counts, red in the lowest bits
    always_comb begin
        for (int i = 0; i < cbc_pkg::NUM_COLORS; i++) begin
            in_counts[i] = s_tdata[i*COUNT_BITS +: COUNT_BITS];
        end
    end

    // sum and total-based thresholds
    cbc_totals #(.COUNT_BITS(COUNT_BITS)) u_totals (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_counts  (in_counts),
        .min_frac   (min_frac_reg),
        .prime_frac (prime_frac_reg),
        .out_valid  (tp_valid),
        .out_ready  (tp_ready),
        .out_counts (tp_counts),
        .out_lo     (tp_lo),
        .out_prime  (tp_prime)
    );

    // winner search and largest-based thresholds
    cbc_peak #(.COUNT_BITS(COUNT_BITS)) u_peak (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (tp_valid),
        .in_ready   (tp_ready),
        .in_counts  (tp_counts),
        .in_lo      (tp_lo),
        .in_prime   (tp_prime),
        .dom_recip  (dom_recip_reg),
        .sec_frac   (sec_frac_reg),
        .out_valid  (pm_valid),
        .out_ready  (pm_ready),
        .out_counts (pm_counts),
        .out_lo     (pm_lo),
        .out_prime  (pm_prime),
        .out_hi     (pm_hi),
        .out_peak   (pm_peak),
        .out_dom_th (pm_dom_th),
        .out_sec_th (pm_sec_th)
    );

    // marking and output register
    cbc_mark #(.COUNT_BITS(COUNT_BITS)) u_mark (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (pm_valid),
        .in_ready      (pm_ready),
        .in_counts     (pm_counts),
        .in_lo         (pm_lo),
        .in_prime      (pm_prime),
        .in_hi         (pm_hi),
        .in_peak       (pm_peak),
        .in_dom_th     (pm_dom_th),
        .in_sec_th     (pm_sec_th),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_primary   (primary_mask),
        .out_secondary (secondary_mask),
        .out_single    (single_dominant)
    );

    assign m_tdata = {PAD_BITS'(0), single_dominant, secondary_mask, primary_mask};

endmodule

@@ rtl/cbc_checker.sv @@
// port-level checks on the color band classifier result channel, bound to the top level
module cbc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [cbc_pkg::OUT_DATA_BITS-1:0]   m_tdata
);
    localparam int NC = cbc_pkg::NUM_COLORS;

    // no result right after a reset cycle
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // a color is never both primary and secondary
    a_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[NC-1:0] & m_tdata[2*NC-1:NC]) == '0)
        else $error("primary and secondary masks overlap");

    // a single dominant winner is the only primary color
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2*NC] |-> $onehot(m_tdata[NC-1:0]))
        else $error("single dominant without exactly one primary");

endmodule

bind color_band_classifier cbc_checker u_cbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/band_marks_checker.sv @@
// checker for the color band classifier: predicts primary and secondary marks, compares results
module band_marks_checker #(
    parameter int COUNT_BITS = cbc_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [((cbc_pkg::NUM_COLORS*COUNT_BITS+7)/8)*8-1:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [cbc_pkg::OUT_DATA_BITS-1:0] m_tdata,
    output int          pending_results,
    output int          mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W = ((cbc_pkg::NUM_COLORS * COUNT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [8:0] primary;
        logic [8:0] secondary;
        logic       single_dom;
    } band_marks_t;

    logic [15:0] min_frac;
    logic [15:0] prime_frac;
    logic [15:0] dom_recip;
    logic [15:0] sec_frac;

    band_marks_t expected_marks[$];
    band_marks_t want;

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    // q0.16 product rounded half up
    function automatic logic [63:0] frac_of(input logic [63:0] value, input logic [15:0] frac);
        return (value * 64'(frac) + 64'd32768) >> 16;
    endfunction

    function automatic band_marks_t predict_marks(input logic [IN_W-1:0] data);
        logic [63:0] cnt [cbc_pkg::NUM_COLORS];
        logic [63:0] total;
        logic [63:0] floor_lvl;
        logic [63:0] prime_lvl;
        logic [63:0] peak;
        logic [63:0] dom_lvl;
        logic [63:0] sec_lvl;
        logic [8:0]  pmask;
        logic [8:0]  smask;
        int          winner;
        band_marks_t marks;
        total = '0;
        for (int k = 0; k < cbc_pkg::NUM_COLORS; k++) begin
            cnt[k] = 64'(data[k*COUNT_BITS +: COUNT_BITS]);
            total += cnt[k];
        end
        floor_lvl = frac_of(total, min_frac);
        prime_lvl = frac_of(total, prime_frac);

        // largest strictly above the minimum, lowest color wins ties
        peak   = floor_lvl;
        winner = -1;
        for (int k = 0; k < cbc_pkg::NUM_COLORS; k++) begin
            if (cnt[k] > peak) begin
                peak   = cnt[k];
                winner = k;
            end
        end

        dom_lvl = frac_of(peak, dom_recip);
        if (winner >= 0) begin
            for (int k = 0; k < cbc_pkg::NUM_COLORS; k++) begin
                if (k != winner && cnt[k] > dom_lvl)
                    winner = -1;
            end
        end

        pmask = '0;
        if (winner >= 0) begin
            pmask[winner] = 1'b1;
        end else if (peak >= prime_lvl) begin
            for (int k = 0; k < cbc_pkg::NUM_COLORS; k++)
                if (cnt[k] > dom_lvl)
                    pmask[k] = 1'b1;
        end

        sec_lvl = frac_of(peak, sec_frac);
        if (sec_lvl < floor_lvl)
            sec_lvl = floor_lvl;
        smask = '0;
        for (int k = 0; k < cbc_pkg::NUM_COLORS; k++)
            if (cnt[k] >= sec_lvl && !pmask[k])
                smask[k] = 1'b1;

        marks.primary    = pmask;
        marks.secondary  = smask;
        marks.single_dom = (winner >= 0);
        return marks;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            min_frac   = cbc_pkg::MIN_FRACTION_RST;
            prime_frac = cbc_pkg::PRIME_FRACTION_RST;
            dom_recip  = cbc_pkg::DOM_RECIP_RST;
            sec_frac   = cbc_pkg::SEC_FRACTION_RST;
            expected_marks.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cbc_pkg::cbc_reg_t'(cfg_addr))
                    cbc_pkg::REG_MIN_FRACTION:   min_frac   = cfg_wdata;
                    cbc_pkg::REG_PRIME_FRACTION: prime_frac = cfg_wdata;
                    cbc_pkg::REG_DOM_RECIP:      dom_recip  = cfg_wdata;
                    cbc_pkg::REG_SEC_FRACTION:   sec_frac   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_marks.push_back(predict_marks(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_marks.size() == 0) begin
                    report_mismatch("result beat with nothing expected", 32'(m_tdata), '0);
                end else begin
                    want = expected_marks.pop_front();
                    // m_tdata: primary [8:0], secondary [17:9], single_dominant [18]
                    if (m_tdata[8:0] !== want.primary)
                        report_mismatch("primary_mask", 32'(m_tdata[8:0]), 32'(want.primary));
                    if (m_tdata[17:9] !== want.secondary)
                        report_mismatch("secondary_mask", 32'(m_tdata[17:9]),
                                        32'(want.secondary));
                    if (m_tdata[18] !== want.single_dom)
                        report_mismatch("single_dominant", 32'(m_tdata[18]),
                                        32'(want.single_dom));
                end
            end
        end
        pending_results <= expected_marks.size();
    end

endmodule

@@ tb/sv/tb_color_band_classifier.sv @@
// top of the color band classifier testbench: clock, reset, stimulus and verdict
module tb_color_band_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB       = cbc_pkg::COUNT_BITS_DEF;
    localparam int DATA_W   = ((cbc_pkg::NUM_COLORS * CB + 7) / 8) * 8;
    localparam int CNT_MAX  = (1 << CB) - 1;
    localparam int PHASES   = 8;
    localparam int PER_PHASE = 168;   // random objects per register setting
    localparam int HOLD_OFF = 300;    // long receiver stall, in cycles
    localparam int SETTLE   = 8;      // settle time once idle, beyond the five-stage pipeline depth

    // color positions inside s_tdata, lowest field first
    typedef enum int {
        RED, ORANGE, YELLOW, GREEN, BLUE, PURPLE, BLACK, GRAY, WHITE
    } color_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [1:0]           cfg_addr  = '0;
    logic [15:0]          cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // red, orange, yellow, green, blue, purple, black, gray, white counts, zero pad
    logic [DATA_W-1:0]    s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // primary_mask [8:0], secondary_mask [17:9], single_dominant [18], zero pad
    logic [cbc_pkg::OUT_DATA_BITS-1:0] m_tdata;

    int          pending_results;
    int          mismatch_count;
    bit          hold_off_req = 1'b0;
    int          gapless_left = 0;
    logic [15:0] cur_dom = cbc_pkg::DOM_RECIP_RST;   // used only to aim counts at the threshold

    color_band_classifier #(.COUNT_BITS(CB)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    band_marks_checker #(.COUNT_BITS(CB)) marks_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb_color_band_classifier failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // object generators
    // ---------------------------------------------------------------

    function automatic logic [DATA_W-1:0] uniform_counts(input int unsigned v);
        logic [DATA_W-1:0] d;
        d = '0;
        for (int k = 0; k < cbc_pkg::NUM_COLORS; k++)
            d[k*CB +: CB] = CB'(v);
        return d;
    endfunction

    function automatic logic [DATA_W-1:0] with_count(input logic [DATA_W-1:0] d,
                                                     input color_t c, input int unsigned v);
        d[int'(c)*CB +: CB] = CB'(v);
        return d;
    endfunction

    // a mix of shapes: flat noise, one clear winner, close contenders, counts right
    // at the dominance level, tiny counts for ties and rounding, sparse, equal and near-full counts
    function automatic logic [DATA_W-1:0] random_counts();
        logic [DATA_W-1:0] d;
        logic [63:0]       lvl;
        int unsigned       big;
        int unsigned       lead;
        int unsigned       style;
        longint            v;
        d     = '0;
        style = $urandom_range(0, 9);
        lead  = $urandom_range(0, cbc_pkg::NUM_COLORS - 1);
        big   = $urandom_range(0, CNT_MAX);
        lvl   = (64'(big) * 64'(cur_dom) + 64'd32768) >> 16;
        for (int k = 0; k < cbc_pkg::NUM_COLORS; k++) begin
            case (style)
                0: d[k*CB +: CB] = CB'($urandom);
                1: d[k*CB +: CB] = (k == lead) ? CB'(big)
                                   : CB'($urandom_range(0, big >> $urandom_range(1, 6)));
                2: d[k*CB +: CB] = ($urandom_range(0, 2) == 0 || k == lead)
                                   ? CB'(big - $urandom_range(0, big >> 3))
                                   : CB'($urandom_range(0, big >> 4));
                3: begin
                    // others sit one below, at, or one above the dominance level, or hold a tiny count
                    v = longint'(lvl) + longint'($urandom_range(0, 2)) - 1;
                    if (v < 0)
                        v = 0;
                    if (v > longint'(big))
                        v = big;
                    d[k*CB +: CB] = (k == lead) ? CB'(big)
                                   : ($urandom_range(0, 1) ? CB'(v) : CB'($urandom_range(0, 3)));
                end
                4: d[k*CB +: CB] = CB'($urandom_range(0, 7));
                5: d[k*CB +: CB] = ($urandom_range(0, 2) == 0) ? CB'($urandom) : '0;
                6: d[k*CB +: CB] = CB'(big);
                7: d[k*CB +: CB] = CB'(CNT_MAX - $urandom_range(0, 3));
                8: d[k*CB +: CB] = (k == lead) ? CB'(big)
                                   : CB'((64'(big) * $urandom_range(0, 100)) / 100);
                default: d[k*CB +: CB] = CB'($urandom >> $urandom_range(0, 31));
            endcase
        end
        return d;
    endfunction

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------

    // mostly back to back or short gaps, now and then a long one,
    // and every so often a run of beats with no gap at all
    function automatic int next_gap();
        int unsigned r;
        if (gapless_left > 0) begin
            gapless_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            gapless_left = $urandom_range(20, 60);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_counts(input logic [DATA_W-1:0] d);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid, let every expected result come back, then let the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cbc_pkg::cbc_reg_t r, input logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        if (r == cbc_pkg::REG_DOM_RECIP)
            cur_dom = v;
        @(posedge aclk);
    endtask

    // register sets per phase: reset values, all zero, all full scale,
    // random, a huge minimum with zero prime (nothing beats the minimum),
    // zero minimum with full-scale rest, random, and back to reset values
    task automatic load_phase(input int p);
        logic [15:0] mn, pr, dm, sc;
        case (p)
            1: begin mn = 16'd0;     pr = 16'd0;     dm = 16'd0;     sc = 16'd0;     end
            2: begin mn = 16'hFFFF;  pr = 16'hFFFF;  dm = 16'hFFFF;  sc = 16'hFFFF;  end
            4: begin mn = 16'hFFFF;  pr = 16'd0;     dm = 16'd20000; sc = 16'd0;     end
            5: begin mn = 16'd0;     pr = 16'hFFFF;  dm = 16'hFFFF;  sc = 16'hFFFF;  end
            7: begin
                mn = cbc_pkg::MIN_FRACTION_RST;
                pr = cbc_pkg::PRIME_FRACTION_RST;
                dm = cbc_pkg::DOM_RECIP_RST;
                sc = cbc_pkg::SEC_FRACTION_RST;
            end
            default: begin
                mn = 16'($urandom_range(0, 16000));
                pr = 16'($urandom);
                dm = 16'($urandom);
                sc = 16'($urandom);
            end
        endcase
        write_reg(cbc_pkg::REG_MIN_FRACTION,   mn);
        write_reg(cbc_pkg::REG_PRIME_FRACTION, pr);
        write_reg(cbc_pkg::REG_DOM_RECIP,      dm);
        write_reg(cbc_pkg::REG_SEC_FRACTION,   sc);
        cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // receiver: random ready, plus a long hold-off on each request
    // ---------------------------------------------------------------
    initial begin
        int unsigned r;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                // long stall so the pipe fills and s_tready drops
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 30)) @(posedge aclk);
                end else if (r < 95) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge aclk);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed objects at reset settings
        // all zero: nothing primary, every color secondary
        send_counts(uniform_counts(0));
        // every count at full scale: nobody beats the others
        send_counts(uniform_counts(CNT_MAX));
        // a lone color, at either end of the bus
        send_counts(with_count(uniform_counts(0), RED, 1000));
        send_counts(with_count(uniform_counts(0), WHITE, CNT_MAX));
        // exact tie between two colors, lower one found first
        send_counts(with_count(with_count(uniform_counts(0), RED, 500), BLUE, 500));
        // clear single winner
        send_counts(with_count(uniform_counts(100), GREEN, 1000));
        // runner-up exactly at the dominance level, then one above
        send_counts(with_count(with_count(uniform_counts(0), RED, 1000), GREEN, 500));
        send_counts(with_count(with_count(uniform_counts(0), RED, 1000), GREEN, 501));
        // rounding half up moves the dominance level
        send_counts(with_count(with_count(uniform_counts(0), RED, 1001), GREEN, 501));
        send_counts(with_count(with_count(uniform_counts(0), RED, 1001), GREEN, 502));
        // secondary level met exactly, then just missed
        send_counts(with_count(with_count(uniform_counts(0), RED, 1000), YELLOW, 300));
        send_counts(with_count(with_count(uniform_counts(0), RED, 1000), YELLOW, 299));
        // flat spread: largest below the prime level, so no primary at all
        send_counts(uniform_counts(100));
        // achromatic colors in the lead
        send_counts(with_count(with_count(uniform_counts(40), BLACK, 9000), GRAY, 8000));
        send_counts(with_count(uniform_counts(3), GRAY, CNT_MAX));
        // three contenders over a small background
        send_counts(with_count(with_count(with_count(uniform_counts(10), ORANGE, 700),
                                          PURPLE, 690), WHITE, 650));
        // alternating bit patterns across the fields
        send_counts({DATA_W/2{2'b01}} & {{(DATA_W - cbc_pkg::NUM_COLORS*CB){1'b0}},
                                         {(cbc_pkg::NUM_COLORS*CB){1'b1}}});
        send_counts({DATA_W/2{2'b10}} & {{(DATA_W - cbc_pkg::NUM_COLORS*CB){1'b0}},
                                         {(cbc_pkg::NUM_COLORS*CB){1'b1}}});

        // random objects under each register setting
        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                wait_idle();
                load_phase(p);
            end
            for (int n = 0; n < PER_PHASE; n++) begin
                if ((p == 0 || p == 3) && n == PER_PHASE / 2)
                    hold_off_req = 1'b1;
                send_counts(random_counts());
            end
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb_color_band_classifier passed");
        else
            $display("tb_color_band_classifier failed");
        $finish;
    end

endmodule
